@@ rtl/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types, selection tables and helpers for the quaternion
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int QW        = 16;
   localparam int VW        = 32;
   localparam int QNW       = QW + 1;
   localparam int PRODW     = 48;
   localparam int PW        = 49;
   localparam int PLOW      = 25;
   localparam int PHIW      = PW - PLOW;
   localparam int HPRODW    = PHIW + QNW;
   localparam int LPRODW    = PLOW + 1 + QNW;
   localparam int TERMW     = 64;
   localparam int SUMW      = 67;
   localparam int FRAC_DROP = 28;
   localparam int OUTW      = 32;

   localparam int NUM_Q   = 4;
   localparam int NUM_V   = 3;
   localparam int NUM_P   = 4;
   localparam int NUM_T1  = 3;
   localparam int NUM_T2  = 4;
   localparam int NUM_OUT = 3;

   localparam int REQ_DATA_W = NUM_Q * QW + NUM_V * VW;
   localparam int RSP_DATA_W = NUM_OUT * OUTW;

   typedef logic [1:0] qsel_type;
   typedef logic [1:0] vsel_type;

   localparam qsel_type Q_I = 2'd0;
   localparam qsel_type Q_J = 2'd1;
   localparam qsel_type Q_K = 2'd2;
   localparam qsel_type Q_R = 2'd3;

   localparam vsel_type V_X = 2'd0;
   localparam vsel_type V_Y = 2'd1;
   localparam vsel_type V_Z = 2'd2;

   typedef logic signed [QW-1:0]     qcomp_type;
   typedef logic signed [QNW-1:0]    qneg_type;
   typedef logic signed [VW-1:0]     vcomp_type;
   typedef logic signed [PRODW-1:0]  prod_type;
   typedef logic signed [PW-1:0]     pcomp_type;
   typedef logic signed [HPRODW-1:0] hprod_type;
   typedef logic signed [LPRODW-1:0] lprod_type;
   typedef logic signed [TERMW-1:0]  tcomp_type;
   typedef logic signed [SUMW-1:0]   sum_type;
   typedef logic signed [OUTW-1:0]   ocomp_type;

   typedef qcomp_type quat_type [NUM_Q];
   typedef vcomp_type vec_type  [NUM_V];
   typedef pcomp_type pvec_type [NUM_P];
   typedef tcomp_type term_type [NUM_OUT][NUM_T2];
   typedef ocomp_type rvec_type [NUM_OUT];

   // p = q * (v, 0), components in order w, x, y, z
   localparam qsel_type P_QSEL [NUM_P][NUM_T1] = '{
      '{Q_I, Q_J, Q_K},
      '{Q_R, Q_J, Q_K},
      '{Q_R, Q_I, Q_K},
      '{Q_R, Q_I, Q_J}
   };
   localparam vsel_type P_VSEL [NUM_P][NUM_T1] = '{
      '{V_X, V_Y, V_Z},
      '{V_X, V_Z, V_Y},
      '{V_Y, V_Z, V_X},
      '{V_Z, V_Y, V_X}
   };
   localparam logic P_NEG [NUM_P][NUM_T1] = '{
      '{1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b1}
   };

   // vector part of p * conj(q); term n uses p component n (w, x, y, z)
   localparam qsel_type T_QSEL [NUM_OUT][NUM_T2] = '{
      '{Q_I, Q_R, Q_K, Q_J},
      '{Q_J, Q_K, Q_R, Q_I},
      '{Q_K, Q_J, Q_I, Q_R}
   };
   localparam logic T_NEG [NUM_OUT][NUM_T2] = '{
      '{1'b1, 1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b1},
      '{1'b1, 1'b1, 1'b0, 1'b0}
   };

   localparam sum_type ROUND_HALF =
      {{(SUMW - FRAC_DROP){1'b0}}, 1'b1, {(FRAC_DROP - 1){1'b0}}};

   localparam logic [OUTW-1:0] OUT_MAX = {1'b0, {(OUTW - 1){1'b1}}};
   localparam logic [OUTW-1:0] OUT_MIN = {1'b1, {(OUTW - 1){1'b0}}};

   function automatic qneg_type q_pick(input quat_type q, input qsel_type s,
                                       input logic neg);
      qneg_type v;
      v = qneg_type'(q[s]);
      return neg ? -v : v;
   endfunction

endpackage

@@ rtl/quaternion_vector_rotate_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a Q16.16 vector by a Q2.14 quaternion as q * (v, 0) * conj(q).
//
//   channel  direction  tdata                              tuser
//   req_     in         quat x,y,z,w (16b), vec x,y,z (32b) -
//   rsp_     out        out x,y,z (32b)                    overflow
//
// One beat enters per cycle while the output is not stalled; a result leaves
// after its beat has passed through the six pipeline registers
// (two multiply stages, two product-term stages, two add stages).
// Reset clears the stage valid bits only.
// A stalled stage holds its beat; empty stages ahead of it keep filling.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
   input  logic [qvr_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_x, out_y, out_z
   output logic [qvr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // overflow
   output logic                             rsp_tuser
);

   qvr_pkg::quat_type  quat_in, quat_a;
   qvr_pkg::vec_type   vec_in;
   qvr_pkg::pvec_type  p_a;
   qvr_pkg::term_type  term_b;
   qvr_pkg::rvec_type  res_c;
   logic               valid_a, ready_a, valid_b, ready_b;

   always_comb begin
      for (int i = 0; i < qvr_pkg::NUM_Q; i++) begin
         quat_in[i] = req_tdata[i*qvr_pkg::QW +: qvr_pkg::QW];
      end
      for (int i = 0; i < qvr_pkg::NUM_V; i++) begin
         vec_in[i] = req_tdata[qvr_pkg::NUM_Q*qvr_pkg::QW + i*qvr_pkg::VW +: qvr_pkg::VW];
      end
      for (int i = 0; i < qvr_pkg::NUM_OUT; i++) begin
         rsp_tdata[i*qvr_pkg::OUTW +: qvr_pkg::OUTW] = res_c[i];
      end
   end

   qvr_pmul u_pmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_quat   (quat_in),
      .in_vec    (vec_in),
      .out_valid (valid_a),
      .out_ready (ready_a),
      .out_quat  (quat_a),
      .out_p     (p_a)
   );

   qvr_cmul u_cmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_a),
      .in_ready  (ready_a),
      .in_quat   (quat_a),
      .in_p      (p_a),
      .out_valid (valid_b),
      .out_ready (ready_b),
      .out_term  (term_b)
   );

   qvr_rsum u_rsum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_b),
      .in_ready  (ready_b),
      .in_term   (term_b),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_vec   (res_c),
      .out_ovf   (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[31:0]  == qvr_pkg::OUT_MAX || rsp_tdata[31:0]  == qvr_pkg::OUT_MIN ||
         rsp_tdata[63:32] == qvr_pkg::OUT_MAX || rsp_tdata[63:32] == qvr_pkg::OUT_MIN ||
         rsp_tdata[95:64] == qvr_pkg::OUT_MAX || rsp_tdata[95:64] == qvr_pkg::OUT_MIN)
      else $error("overflow flagged without a saturated component");

   a_full_pipe: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the output is free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");
`endif

endmodule

@@ rtl/qvr_pmul.sv @@
// ----------------------------------------------------------------------------
// qvr_pmul
// First Hamilton product p = q * (v, 0): a product stage and a sum stage.
// ----------------------------------------------------------------------------
module qvr_pmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qvr_pkg::quat_type  in_quat,
   input  qvr_pkg::vec_type   in_vec,
   output logic               out_valid,
   input  logic               out_ready,
   output qvr_pkg::quat_type  out_quat,
   output qvr_pkg::pvec_type  out_p
);

   logic                 v1_ff, v2_ff;
   logic                 en1, en2;
   qvr_pkg::prod_type    prod_ff [qvr_pkg::NUM_P][qvr_pkg::NUM_T1];
   qvr_pkg::prod_type    prod_in [qvr_pkg::NUM_P][qvr_pkg::NUM_T1];
   qvr_pkg::quat_type    quat1_ff, quat2_ff;
   qvr_pkg::pvec_type    p_ff, p_in;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      logic signed [qvr_pkg::QNW+qvr_pkg::VW-1:0] full;
      qvr_pkg::qneg_type                          qn;
      full = '0;
      qn   = '0;
      for (int m = 0; m < qvr_pkg::NUM_P; m++) begin
         for (int n = 0; n < qvr_pkg::NUM_T1; n++) begin
            qn   = qvr_pkg::q_pick(in_quat, qvr_pkg::P_QSEL[m][n], qvr_pkg::P_NEG[m][n]);
            full = (qvr_pkg::QNW+qvr_pkg::VW)'(qn)
                 * (qvr_pkg::QNW+qvr_pkg::VW)'(in_vec[qvr_pkg::P_VSEL[m][n]]);
            prod_in[m][n] = full[qvr_pkg::PRODW-1:0];
         end
      end
   end

   always_comb begin
      for (int m = 0; m < qvr_pkg::NUM_P; m++) begin
         p_in[m] = qvr_pkg::pcomp_type'(prod_ff[m][0])
                 + qvr_pkg::pcomp_type'(prod_ff[m][1])
                 + qvr_pkg::pcomp_type'(prod_ff[m][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
      if (en1) begin
         prod_ff  <= prod_in;
         quat1_ff <= in_quat;
      end
      if (en2) begin
         p_ff     <= p_in;
         quat2_ff <= quat1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_quat  = quat2_ff;
   assign out_p     = p_ff;

endmodule

@@ rtl/qvr_cmul.sv @@
// ----------------------------------------------------------------------------
// qvr_cmul
// Second Hamilton product against conj(q): split partial products, then
// the twelve exact signed terms.
// ----------------------------------------------------------------------------
module qvr_cmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qvr_pkg::quat_type  in_quat,
   input  qvr_pkg::pvec_type  in_p,
   output logic               out_valid,
   input  logic               out_ready,
   output qvr_pkg::term_type  out_term
);

   logic                 v3_ff, v4_ff;
   logic                 en3, en4;
   qvr_pkg::hprod_type   hi_ff [qvr_pkg::NUM_OUT][qvr_pkg::NUM_T2];
   qvr_pkg::hprod_type   hi_in [qvr_pkg::NUM_OUT][qvr_pkg::NUM_T2];
   qvr_pkg::lprod_type   lo_ff [qvr_pkg::NUM_OUT][qvr_pkg::NUM_T2];
   qvr_pkg::lprod_type   lo_in [qvr_pkg::NUM_OUT][qvr_pkg::NUM_T2];
   qvr_pkg::term_type    term_ff, term_in;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign in_ready = en3;

   always_comb begin
      qvr_pkg::qneg_type qn;
      qn = '0;
      for (int c = 0; c < qvr_pkg::NUM_OUT; c++) begin
         for (int n = 0; n < qvr_pkg::NUM_T2; n++) begin
            qn = qvr_pkg::q_pick(in_quat, qvr_pkg::T_QSEL[c][n], qvr_pkg::T_NEG[c][n]);
            hi_in[c][n] =
               qvr_pkg::hprod_type'($signed(in_p[n][qvr_pkg::PW-1:qvr_pkg::PLOW]))
               * qvr_pkg::hprod_type'(qn);
            lo_in[c][n] =
               qvr_pkg::lprod_type'($signed({1'b0, in_p[n][qvr_pkg::PLOW-1:0]}))
               * qvr_pkg::lprod_type'(qn);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < qvr_pkg::NUM_OUT; c++) begin
         for (int n = 0; n < qvr_pkg::NUM_T2; n++) begin
            term_in[c][n] = (qvr_pkg::tcomp_type'(hi_ff[c][n]) <<< qvr_pkg::PLOW)
                          + qvr_pkg::tcomp_type'(lo_ff[c][n]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
      end
      if (en3) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (en4) term_ff <= term_in;
   end

   assign out_valid = v4_ff;
   assign out_term  = term_ff;

endmodule

@@ rtl/qvr_rsum.sv @@
// ----------------------------------------------------------------------------
// qvr_rsum
// Sum of four terms per component, round to nearest and saturate.
// ----------------------------------------------------------------------------
module qvr_rsum (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qvr_pkg::term_type  in_term,
   output logic               out_valid,
   input  logic               out_ready,
   output qvr_pkg::rvec_type  out_vec,
   output logic               out_ovf
);

   logic                 v5_ff, v6_ff;
   logic                 en5, en6;
   qvr_pkg::sum_type     pa_ff [qvr_pkg::NUM_OUT];
   qvr_pkg::sum_type     pa_in [qvr_pkg::NUM_OUT];
   qvr_pkg::sum_type     pb_ff [qvr_pkg::NUM_OUT];
   qvr_pkg::sum_type     pb_in [qvr_pkg::NUM_OUT];
   qvr_pkg::rvec_type    res_ff, res_in;
   logic                 ovf_ff, ovf_in;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign in_ready = en5;

   always_comb begin
      for (int c = 0; c < qvr_pkg::NUM_OUT; c++) begin
         pa_in[c] = qvr_pkg::sum_type'(in_term[c][0]) + qvr_pkg::sum_type'(in_term[c][1])
                  + qvr_pkg::ROUND_HALF;
         pb_in[c] = qvr_pkg::sum_type'(in_term[c][2]) + qvr_pkg::sum_type'(in_term[c][3]);
      end
   end

   always_comb begin
      qvr_pkg::sum_type                                          s;
      logic [qvr_pkg::SUMW-qvr_pkg::FRAC_DROP-qvr_pkg::OUTW:0]    top;
      s      = '0;
      top    = '0;
      ovf_in = 1'b0;
      for (int c = 0; c < qvr_pkg::NUM_OUT; c++) begin
         s   = pa_ff[c] + pb_ff[c];
         top = s[qvr_pkg::SUMW-1:qvr_pkg::FRAC_DROP+qvr_pkg::OUTW-1];
         if ((&top) || !(|top)) begin
            res_in[c] = s[qvr_pkg::FRAC_DROP+qvr_pkg::OUTW-1:qvr_pkg::FRAC_DROP];
         end else begin
            res_in[c] = s[qvr_pkg::SUMW-1] ? qvr_pkg::OUT_MIN : qvr_pkg::OUT_MAX;
            ovf_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en5) v5_ff <= in_valid;
         if (en6) v6_ff <= v5_ff;
      end
      if (en5) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (en6) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_vec   = res_ff;
   assign out_ovf   = ovf_ff;

endmodule
